>>> sv/kti_pkg.sv
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants of the keyframe track interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kti_pkg;

    localparam int unsigned TRACKS_DEF    = 8;
    localparam int unsigned KEYS_DEF      = 64;
    localparam int unsigned FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_SETV   = 3'd2,
        OP_SETM   = 3'd3,
        OP_EVAL   = 3'd4
    } t_op;

    localparam logic [1:0] MODE_CONST  = 2'd1;
    localparam logic [1:0] MODE_SMOOTH = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic [2:0]         track_select;
        logic signed [15:0] frame;
        logic signed [31:0] key_value_in;
        logic [1:0]         interp_mode;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic signed [15:0] frame;
        logic signed [31:0] value;
        logic [1:0]         mode;
    } t_entry;

    // what a cell does with its slot of the selected track
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_REMOVE,
        ACT_REPLACE,
        ACT_SETV,
        ACT_SETM
    } t_act;

    typedef struct packed {
        logic ge;        // slot is not a valid key below the frame
        logic at_pos;    // first slot at or above the frame
        logic pos_valid; // at_pos and slot holds a key
        logic at_prev;   // last key below the frame
    } t_flags;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_ACT,
        S_DIV,
        S_SQ,
        S_SM,
        S_MLO,
        S_MHI
    } t_state;

endpackage

`default_nettype wire

>>> sv/kti_ram.sv
// ----------------------------------------------------------------------------
// kti_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic                                     i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/kti_cell.sv
// ----------------------------------------------------------------------------
// kti_cell
// One key slot of every track: slot RAM, compare against the frame, and
// the shift from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_cell #(
    parameter int unsigned TRACKS = 8,
    parameter int unsigned IDX    = 0,
    parameter int unsigned CW     = 7,
    parameter int unsigned TW     = 3
) (
    input  wire logic            i_clk,
    input  wire logic            i_rd_en,
    input  wire logic [TW-1:0]   i_rd_trk,
    input  wire logic [TW-1:0]   i_wr_trk,
    input  wire logic [CW-1:0]   i_cnt,
    input  wire kti_pkg::t_act   i_act,
    input  wire kti_pkg::t_entry i_key,
    input  wire kti_pkg::t_entry i_left,
    input  wire kti_pkg::t_entry i_right,
    input  wire logic            i_ge_left,
    input  wire logic            i_ge_right,
    output kti_pkg::t_entry      o_entry,
    output kti_pkg::t_flags      o_flags
);
    import kti_pkg::*;

    t_entry c_rd;
    t_entry c_wd;
    logic   c_we;
    logic   c_valid;
    logic   c_ge;
    logic   c_at_pos;

    kti_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TRACKS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (c_we),
        .i_wr_addr (i_wr_trk),
        .i_wr_data (c_wd),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_trk),
        .o_rd_data (c_rd)
    );

    always_comb begin
        c_valid  = CW'(IDX) < i_cnt;
        c_ge     = !(c_valid && (c_rd.frame < i_key.frame));
        c_at_pos = c_ge && !i_ge_left;
        c_we     = 1'b0;
        c_wd     = i_key;
        unique case (i_act)
            ACT_INSERT: begin
                c_we = i_ge_left || c_at_pos;
                c_wd = i_ge_left ? i_left : i_key;
            end
            ACT_REMOVE: begin
                c_we = c_ge;
                c_wd = i_right;
            end
            ACT_REPLACE: begin
                c_we = c_at_pos;
            end
            ACT_SETV: begin
                c_we = c_at_pos;
                c_wd = '{frame: c_rd.frame, value: i_key.value, mode: c_rd.mode};
            end
            ACT_SETM: begin
                c_we = c_at_pos;
                c_wd = '{frame: c_rd.frame, value: c_rd.value, mode: i_key.mode};
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
    end

    assign o_entry = c_rd;
    assign o_flags = '{ge: c_ge, at_pos: c_at_pos, pos_valid: c_at_pos && c_valid,
                       at_prev: !c_ge && i_ge_right};

endmodule

`default_nettype wire

>>> sv/keyframe_track_interpolator_unit.sv
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_unit
// Sorted keyframe lists per track with add, remove, edit and evaluate.
// ----------------------------------------------------------------------------
// Usage: present an item on i_item and raise i_start; it is taken at an edge
// with o_busy low. Exactly one result per item appears on o_result for one
// cycle with o_strobe high; the receiver cannot stall it, and the next item
// may be taken in the strobe cycle.
// Keys live in a row of KEYS_PER_TRACK cells, one slot each, with a small
// RAM per cell indexed by track. The track is read from all cells on accept,
// S_LOOK finds the position and S_ACT writes (shifting by neighbor).
// Steps from accept to strobe:
//   edits, and evaluate without blending: S_LOOK, S_ACT
//   linear blend:     S_LOOK, S_ACT, S_DIV (bit-serial divide), S_MLO, S_MHI
//   smoothstep blend: as linear, with two extra multiply stages S_SQ, S_SM
// The final multiply is split in two partial products, S_MLO then S_MHI.
// Reset clears the per-track key counts; key RAM contents need no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_track_interpolator_unit #(
    parameter int unsigned TRACKS         = kti_pkg::TRACKS_DEF,
    parameter int unsigned KEYS_PER_TRACK = kti_pkg::KEYS_DEF,
    parameter int unsigned FRAC_BITS      = kti_pkg::FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire kti_pkg::t_in i_item,
    output logic              o_busy,
    output logic              o_strobe,
    output kti_pkg::t_out     o_result
);
    import kti_pkg::*;

    localparam int unsigned K  = KEYS_PER_TRACK;
    localparam int unsigned FB = FRAC_BITS;
    localparam int unsigned TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int unsigned CW = $clog2(K + 1);
    localparam int unsigned DW = $clog2(FB + 1);
    localparam int unsigned PW = FB + 35;

    t_state r_state, n_state;
    t_in    r_item;
    logic [TW-1:0] r_trk;
    logic [CW-1:0] r_cnt [TRACKS];
    logic [CW-1:0] n_cnt_sel;
    logic          c_cnt_we;

    logic   r_hit, r_full, r_posv, r_prev_any, r_zero;
    t_entry r_epos, r_eprev;
    logic   n_hit, n_posv, n_prev_any;
    t_entry n_epos, n_eprev;

    logic [15:0]   r_rem, n_rem;
    logic [15:0]   r_span, n_span;
    logic [FB-1:0] r_q, n_q;
    logic [DW-1:0] r_dcnt, n_dcnt;
    logic [FB-1:0] r_t2, n_t2;
    logic [FB:0]   r_s, n_s;
    logic signed [32:0] r_diff, n_diff;
    logic signed [31:0] r_v0, n_v0;
    logic [FB+16:0]     r_plo, n_plo;
    logic          r_smooth, n_smooth;

    t_out   r_res, n_res;
    logic   r_strobe, n_strobe;

    t_act   c_act;
    logic   c_accept;
    logic [2:0]    c_msel;
    logic [TW-1:0] c_trk;
    logic [CW-1:0] c_cnt;
    t_entry        c_key;

    t_entry c_ent [K];
    t_flags c_flg [K];

    assign c_accept = i_start && (r_state == S_IDLE);
    assign c_cnt    = r_cnt[r_trk];
    assign c_key    = '{frame: r_item.frame, value: r_item.key_value_in,
                        mode: r_item.interp_mode};

    // track index modulo TRACKS by repeated subtract of a 3-bit value
    always_comb begin
        c_msel = i_item.track_select;
        for (int i = 0; i < 8; i++) begin
            if (32'(c_msel) >= TRACKS) begin
                c_msel = c_msel - 3'(TRACKS);
            end
        end
        c_trk = TW'(c_msel);
    end

    for (genvar g = 0; g < K; g++) begin : g_cell
        kti_cell #(
            .TRACKS (TRACKS),
            .IDX    (g),
            .CW     (CW),
            .TW     (TW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rd_en    (c_accept),
            .i_rd_trk   (c_trk),
            .i_wr_trk   (r_trk),
            .i_cnt      (c_cnt),
            .i_act      (c_act),
            .i_key      (c_key),
            .i_left     ((g == 0) ? c_key : c_ent[(g == 0) ? 0 : g - 1]),
            .i_right    ((g == K - 1) ? c_key : c_ent[(g == K - 1) ? g : g + 1]),
            .i_ge_left  ((g == 0) ? 1'b0 : c_flg[(g == 0) ? 0 : g - 1].ge),
            .i_ge_right ((g == K - 1) ? 1'b1 : c_flg[(g == K - 1) ? g : g + 1].ge),
            .o_entry    (c_ent[g]),
            .o_flags    (c_flg[g])
        );
    end

    // one-hot gather of the key at the position and the key before it
    always_comb begin
        n_hit      = 1'b0;
        n_posv     = 1'b0;
        n_prev_any = 1'b0;
        n_epos     = '0;
        n_eprev    = '0;
        for (int i = 0; i < K; i++) begin
            if (c_flg[i].pos_valid) begin
                n_epos = n_epos | c_ent[i];
                n_posv = 1'b1;
            end
            if (c_flg[i].at_prev) begin
                n_eprev    = n_eprev | c_ent[i];
                n_prev_any = 1'b1;
            end
        end
        n_hit = n_posv && (n_epos.frame == r_item.frame);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            for (int i = 0; i < TRACKS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (c_cnt_we) begin
                r_cnt[r_trk] <= n_cnt_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_item <= i_item;
            r_trk  <= c_trk;
        end
        if (r_state == S_LOOK) begin
            r_hit      <= n_hit;
            r_full     <= c_cnt == CW'(K);
            r_zero     <= c_cnt == '0;
            r_posv     <= n_posv;
            r_prev_any <= n_prev_any;
            r_epos     <= n_epos;
            r_eprev    <= n_eprev;
        end
        r_rem    <= n_rem;
        r_span   <= n_span;
        r_q      <= n_q;
        r_dcnt   <= n_dcnt;
        r_t2     <= n_t2;
        r_s      <= n_s;
        r_diff   <= n_diff;
        r_v0     <= n_v0;
        r_plo    <= n_plo;
        r_smooth <= n_smooth;
        r_res    <= n_res;
    end

    logic [16:0]         c_sh;
    logic [2*FB-1:0]     c_sq;
    logic [FB+1:0]       c_fac;
    logic [2*FB+1:0]     c_smp;
    logic signed [FB+18:0] c_phi;
    logic signed [PW-1:0]  c_p;
    logic signed [16:0]  c_d0;
    logic signed [16:0]  c_d1;

    always_comb begin
        n_state   = r_state;
        n_strobe  = 1'b0;
        n_res     = r_res;
        n_rem     = r_rem;
        n_span    = r_span;
        n_q       = r_q;
        n_dcnt    = r_dcnt;
        n_t2      = r_t2;
        n_s       = r_s;
        n_diff    = r_diff;
        n_v0      = r_v0;
        n_plo     = r_plo;
        n_smooth  = r_smooth;
        c_act     = ACT_NONE;
        c_cnt_we  = 1'b0;
        n_cnt_sel = c_cnt;
        c_sh      = {r_rem, 1'b0};
        c_sq      = r_q * r_q;
        c_fac     = ((FB + 2)'(3) << FB) - (FB + 2)'({r_q, 1'b0});
        c_smp     = r_t2 * c_fac;
        c_phi     = $signed(r_diff[32:16]) * $signed({1'b0, r_s});
        c_p       = ({{(PW - FB - 19){c_phi[FB+18]}}, c_phi} <<< 16)
                    + $signed({{(PW - FB - 17){1'b0}}, r_plo});
        c_d0      = 17'(r_item.frame) - 17'(r_eprev.frame);
        c_d1      = 17'(r_epos.frame) - 17'(r_eprev.frame);
        unique case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_ACT;
            end
            S_ACT: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_res    = '{result_value: '0, status: ST_DONE};
                unique case (t_op'(r_item.operation))
                    OP_ADD: begin
                        if (r_hit) begin
                            c_act = ACT_REPLACE;
                        end else if (r_full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            c_act     = ACT_INSERT;
                            c_cnt_we  = 1'b1;
                            n_cnt_sel = c_cnt + 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_hit) begin
                            c_act     = ACT_REMOVE;
                            c_cnt_we  = 1'b1;
                            n_cnt_sel = c_cnt - 1'b1;
                        end else begin
                            n_res.status = ST_MISSING;
                        end
                    end
                    OP_SETV: begin
                        if (r_hit) c_act = ACT_SETV;
                        else n_res.status = ST_MISSING;
                    end
                    OP_SETM: begin
                        if (r_hit) c_act = ACT_SETM;
                        else n_res.status = ST_MISSING;
                    end
                    OP_EVAL: begin
                        priority if (r_zero) begin
                            n_res.result_value = '0;
                        end else if (r_hit || !r_prev_any) begin
                            n_res.result_value = r_epos.value;
                        end else if (!r_posv || r_eprev.mode == MODE_CONST) begin
                            n_res.result_value = r_eprev.value;
                        end else begin
                            n_strobe = 1'b0;
                            n_state  = S_DIV;
                            n_rem    = c_d0[15:0];
                            n_span   = c_d1[15:0];
                            n_q      = '0;
                            n_dcnt   = '0;
                            n_v0     = r_eprev.value;
                            n_diff   = 33'(r_epos.value) - 33'(r_eprev.value);
                            n_smooth = r_eprev.mode == MODE_SMOOTH;
                        end
                    end
                    default: begin
                        n_res.status = ST_DONE;
                    end
                endcase
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (c_sh >= {1'b0, r_span}) begin
                    n_rem = 16'(c_sh - {1'b0, r_span});
                    n_q   = {r_q[FB-2:0], 1'b1};
                end else begin
                    n_rem = c_sh[15:0];
                    n_q   = {r_q[FB-2:0], 1'b0};
                end
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DW'(FB - 1)) begin
                    n_state = r_smooth ? S_SQ : S_MLO;
                    n_s     = {1'b0, n_q};
                end
            end
            S_SQ: begin
                n_t2    = c_sq[2*FB-1:FB];
                n_state = S_SM;
            end
            S_SM: begin
                n_s     = c_smp[2*FB:FB];
                n_state = S_MLO;
            end
            S_MLO: begin
                n_plo   = r_diff[15:0] * r_s;
                n_state = S_MHI;
            end
            S_MHI: begin
                // arithmetic shift gives the floor of the signed product
                n_res    = '{result_value: r_v0 + 32'(c_p >>> FB), status: ST_DONE};
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

`default_nettype wire

>>> sv/kti_checker.sv
// ----------------------------------------------------------------------------
// kti_checker
// Port-level checks of the interpolator handshake and results.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_start,
    input wire logic          o_busy,
    input wire logic          o_strobe,
    input wire kti_pkg::t_out o_result
);
    import kti_pkg::*;

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_strobe))
        else $error("accepted item did not raise busy");

    a_one_shot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_idle_at_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !o_busy)
        else $error("result while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.status <= ST_FULL))
        else $error("invalid status");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_DONE) |-> (o_result.result_value == '0))
        else $error("nonzero value with error status");

endmodule

bind keyframe_track_interpolator_unit kti_checker u_kti_checker (.*);

`default_nettype wire
